// ----- hw/rtl/vpmc_pkg.sv -----
// Shared constants, codes and types of the pixel model classifier.
package vpmc_pkg;

	localparam int NUM_SAMPLES = 20;
	localparam int MAX_PIXELS  = 131072;
	localparam int PIX_AW      = $clog2(MAX_PIXELS);

	localparam int ACTION_W   = 2;
	localparam int PIXEL_W    = 17;
	localparam int VALUE_W    = 8;
	localparam int SLOT_W     = 5;
	localparam int RADIUS_W   = 8;
	localparam int MINM_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam int CNT_W     = $clog2(NUM_SAMPLES + 1);
	localparam int GRP_SIZE  = 8;
	localparam int NUM_GRPS  = (NUM_SAMPLES + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_CNT_W = $clog2(GRP_SIZE + 1);

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd20;
	localparam logic [MINM_W-1:0]   MINM_RESET   = 5'd2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INIT    = 2'd0,
		ACT_DETECT  = 2'd1,
		ACT_REPLACE = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_RADIUS = 1'b0,
		REG_MIN_MATCHES  = 1'b1
	} cfg_reg_t;

	typedef logic [NUM_SAMPLES-1:0][VALUE_W-1:0] sample_row_t;
	typedef logic [NUM_SAMPLES-1:0]              sample_mask_t;
	typedef logic [NUM_GRPS-1:0][GRP_CNT_W-1:0]  grp_cnt_t;

	typedef struct packed {
		logic               rd_en;
		sample_mask_t       wr_en;
		logic [PIX_AW-1:0]  addr;
		logic [VALUE_W-1:0] wr_value;
	} mem_req_t;

endpackage

// ----- hw/rtl/vpmc_sample_mem.sv -----
// Sample store: one row of all samples per pixel, per-sample write enables, registered read.
module vpmc_sample_mem (
	input  logic                  clk,
	input  vpmc_pkg::mem_req_t    req,
	output vpmc_pkg::sample_row_t row_s2
);
	import vpmc_pkg::*;

	sample_row_t store_q [MAX_PIXELS];

	always_ff @(posedge clk) begin
		for (int s = 0; s < NUM_SAMPLES; s++) begin
			if (req.wr_en[s]) begin
				store_q[req.addr][s] <= req.wr_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			row_s2 <= store_q[req.addr];
		end
	end

endmodule

// ----- hw/rtl/vpmc_match_stage.sv -----
// Match stage: per-sample absolute grey difference against the radius.
module vpmc_match_stage (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          match_en,
	input  logic [vpmc_pkg::VALUE_W-1:0]  value,
	input  vpmc_pkg::sample_row_t         row,
	input  logic [vpmc_pkg::RADIUS_W-1:0] radius,
	output vpmc_pkg::sample_mask_t        match_s3
);
	import vpmc_pkg::*;

	logic [NUM_SAMPLES-1:0][VALUE_W-1:0] diff;
	sample_mask_t                        hit;

	always_comb begin
		for (int s = 0; s < NUM_SAMPLES; s++) begin
			diff[s] = (value >= row[s]) ? (value - row[s]) : (row[s] - value);
			hit[s]  = match_en && (diff[s] < radius);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			match_s3 <= hit;
		end
	end

endmodule

// ----- hw/rtl/vpmc_count_stage.sv -----
// Count stage: population count of the match bits in groups of eight.
module vpmc_count_stage (
	input  logic                   clk,
	input  logic                   load,
	input  vpmc_pkg::sample_mask_t match_s3,
	output vpmc_pkg::grp_cnt_t     grp_cnt_s4
);
	import vpmc_pkg::*;

	localparam int PAD_W = NUM_GRPS * GRP_SIZE;

	logic [PAD_W-1:0] padded;
	grp_cnt_t         grp_cnt;

	always_comb begin
		padded = PAD_W'(match_s3);
		for (int g = 0; g < NUM_GRPS; g++) begin
			grp_cnt[g] = '0;
			for (int b = 0; b < GRP_SIZE; b++) begin
				grp_cnt[g] = grp_cnt[g] + GRP_CNT_W'(padded[g * GRP_SIZE + b]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_cnt_s4 <= grp_cnt;
		end
	end

endmodule

// ----- hw/rtl/vibe_pixel_model_classifier_unit.sv -----
// Top level of the per-pixel background model and foreground classifier.
//
// Input channel (in_valid/in_ready) transfers one item: action, pixel_index,
// pixel_value, sample_slot. Init fills every sample of the pixel, replace
// overwrites one sample, detect compares the value with all stored samples.
// Output channel (out_valid/out_ready) transfers exactly one is_foreground
// per item, in order; it is 0 for init, replace and the unused action.
// Five register stages: input, sample row read, match bits, group counts,
// result. One item enters every cycle while no output stall backs up to
// the input; an item reads and writes its sample row as it moves into the
// second stage. Writes land before any later read, so a detect right
// behind an init or replace of the same pixel sees the new data.
// A stall at the output backs up stage by stage; empty stages still fill, so
// the input keeps taking items until every stage holds one. Reset clears
// the pipeline and loads match_radius 20, min_matches 2. The sample store
// is not cleared: a pixel must be initialized before detect. The user must
// write configuration (cfg_we/cfg_index/cfg_wdata) only while idle, unchecked.
module vibe_pixel_model_classifier_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vpmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [vpmc_pkg::ACTION_W-1:0]   action,
	input  logic [vpmc_pkg::PIXEL_W-1:0]    pixel_index,
	input  logic [vpmc_pkg::VALUE_W-1:0]    pixel_value,
	input  logic [vpmc_pkg::SLOT_W-1:0]     sample_slot,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            is_foreground
);
	import vpmc_pkg::*;

	// configuration registers
	logic [RADIUS_W-1:0] match_radius_q;
	logic [MINM_W-1:0]   min_matches_q;

	// stage valids and per-stage ready (stage loads when empty or draining)
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// stage 1: captured input item
	logic [ACTION_W-1:0] action_s1;
	logic [PIXEL_W-1:0]  pixel_s1;
	logic [VALUE_W-1:0]  value_s1;
	logic [SLOT_W-1:0]   slot_s1;

	// stage 2: sample row plus item attributes
	logic               detect_s2, match_en_s2;
	logic [VALUE_W-1:0] value_s2;
	sample_row_t        row_s2;

	// stage 3 and 4
	logic         detect_s3, detect_s4;
	sample_mask_t match_s3;
	grp_cnt_t     grp_cnt_s4;

	// stage 5: result register
	logic fg_s5;

	// stage 1 decode
	logic         pixel_ok, slot_ok, is_detect;
	sample_mask_t wr_mask;
	mem_req_t     mem_req;

	// stage 4 threshold
	logic [CNT_W-1:0] total;
	logic             fg_next;

	// config writes: decode the register index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_radius_q <= RADIUS_RESET;
			min_matches_q  <= MINM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MATCH_RADIUS: match_radius_q <= cfg_wdata[RADIUS_W-1:0];
				REG_MIN_MATCHES:  min_matches_q  <= cfg_wdata[MINM_W-1:0];
				default: ;
			endcase
		end
	end

	// ready chain from the output back to the input
	assign rdy_s5   = !valid_s5 || out_ready;
	assign rdy_s4   = !valid_s4 || rdy_s5;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// stage 1: hold the transferred item
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			action_s1 <= action;
			pixel_s1  <= pixel_index;
			value_s1  <= pixel_value;
			slot_s1   <= sample_slot;
		end
	end

	// Decode the action into sample write enables and the detect flag.
	// Out-of-range pixels write nothing and match nothing, but a detect still
	// reports against min_matches with a count of zero.
	always_comb begin
		pixel_ok  = 32'(pixel_s1) < MAX_PIXELS;
		slot_ok   = 32'(slot_s1) < NUM_SAMPLES;
		wr_mask   = '0;
		is_detect = 1'b0;
		unique case (action_t'(action_s1))
			ACT_INIT: begin
				if (pixel_ok) begin
					wr_mask = '1;
				end
			end
			ACT_DETECT: begin
				is_detect = 1'b1;
			end
			ACT_REPLACE: begin
				if (pixel_ok && slot_ok) begin
					wr_mask = sample_mask_t'(1) << slot_s1;
				end
			end
			default: ;
		endcase
	end

	// Read and write only as the item moves into stage 2, so a stall neither
	// repeats a write nor loses the read row.
	always_comb begin
		mem_req.rd_en    = rdy_s2;
		mem_req.wr_en    = (valid_s1 && rdy_s2) ? wr_mask : '0;
		mem_req.addr     = PIX_AW'(pixel_s1);
		mem_req.wr_value = value_s1;
	end

	vpmc_sample_mem u_mem (
		.clk    (clk),
		.req    (mem_req),
		.row_s2 (row_s2)
	);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			detect_s2   <= is_detect;
			match_en_s2 <= is_detect && pixel_ok;
			value_s2    <= value_s1;
		end
	end

	// stage 2 -> 3: per-sample match
	vpmc_match_stage u_match (
		.clk      (clk),
		.load     (rdy_s3),
		.match_en (match_en_s2),
		.value    (value_s2),
		.row      (row_s2),
		.radius   (match_radius_q),
		.match_s3 (match_s3)
	);

	// stage 3 -> 4: grouped match counts
	vpmc_count_stage u_count (
		.clk        (clk),
		.load       (rdy_s4),
		.match_s3   (match_s3),
		.grp_cnt_s4 (grp_cnt_s4)
	);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			detect_s3 <= detect_s2;
		end
		if (rdy_s4) begin
			detect_s4 <= detect_s3;
		end
	end

	// stage 4: add the group counts, foreground when below min_matches
	always_comb begin
		total = '0;
		for (int g = 0; g < NUM_GRPS; g++) begin
			total = total + CNT_W'(grp_cnt_s4[g]);
		end
		fg_next = detect_s4 && (32'(total) < 32'(min_matches_q));
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			fg_s5 <= fg_next;
		end
	end

	assign out_valid     = valid_s5;
	assign is_foreground = fg_s5;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("transferred item missing from stage 1");

	a_row_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rdy_s3) |=> (valid_s2 && $stable(row_s2)))
		else $error("sample row changed while stage 2 stalled");

	a_non_detect_background: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && rdy_s5 && !detect_s4) |=> !fg_s5)
		else $error("init or replace reported foreground");
`endif

endmodule

// ----- tb/vibe_pixel_model_classifier_unit_test.sv -----
// Self-checking testbench for the per-pixel background model and classifier unit.
module vibe_pixel_model_classifier_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import vpmc_pkg::*;

	// Expected foreground flags, worked out from a private copy of the sample store
	// and of both registers; every input transfer queues exactly one flag.
	class fg_board;
		logic [RADIUS_W-1:0] radius;
		logic [MINM_W-1:0]   min_count;
		sample_row_t         rows [int];
		bit                  fg_expected [$];
		int                  errors;

		function new();
			radius    = RADIUS_RESET;
			min_count = MINM_RESET;
			errors    = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_MATCH_RADIUS)
				radius = data[RADIUS_W-1:0];
			else
				min_count = data[MINM_W-1:0];
		endfunction

		// Apply one accepted item to the store and queue its flag.
		function void take_item(logic [ACTION_W-1:0] act, logic [PIXEL_W-1:0] pix,
				logic [VALUE_W-1:0] val, logic [SLOT_W-1:0] slot);
			sample_row_t row;
			int hits;
			int gap;
			bit fg;
			fg = 1'b0;
			case (act)
				ACT_INIT: begin
					for (int s = 0; s < NUM_SAMPLES; s++)
						row[s] = val;
					rows[int'(pix)] = row;
				end
				ACT_DETECT: begin
					row  = rows.exists(int'(pix)) ? rows[int'(pix)] : '0;
					hits = 0;
					for (int s = 0; s < NUM_SAMPLES; s++) begin
						gap = (val > row[s]) ? int'(val) - int'(row[s])
						                     : int'(row[s]) - int'(val);
						if (gap < int'(radius))
							hits++;
					end
					fg = (hits < int'(min_count));
				end
				ACT_REPLACE: begin
					if (slot < NUM_SAMPLES) begin
						row = rows.exists(int'(pix)) ? rows[int'(pix)] : '0;
						row[slot] = val;
						rows[int'(pix)] = row;
					end
				end
				default: ;
			endcase
			fg_expected.push_back(fg);
		endfunction

		function void check_fg(logic fg);
			bit want;
			if (fg_expected.size() == 0) begin
				$display("%0t: is_foreground %0b arrived with no result pending", $time, fg);
				errors++;
			end else begin
				want = fg_expected.pop_front();
				if (fg !== want) begin
					$display("%0t: is_foreground mismatch, expected %0b, actual %0b",
						$time, want, fg);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [ACTION_W-1:0]   action      = '0;
	logic [PIXEL_W-1:0]    pixel_index = '0;
	logic [VALUE_W-1:0]    pixel_value = '0;
	logic [SLOT_W-1:0]     sample_slot = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic                  is_foreground;

	fg_board board = new();

	// Stimulus bookkeeping: pixels whose samples are all written may be detected.
	bit   primed [int];
	bit   calm = 1'b0;
	int   cur_radius = int'(RADIUS_RESET);
	int   pool_pix [24];
	int   pool_base [24];

	vibe_pixel_model_classifier_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.pixel_index   (pixel_index),
		.pixel_value   (pixel_value),
		.sample_slot   (sample_slot),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.is_foreground (is_foreground)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the output side at random, except during a calm phase.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 35);
	end

	// Watch both channels; check the result first, then note the new input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_fg(is_foreground);
			if (in_valid && in_ready)
				board.take_item(action, pixel_index, pixel_value, sample_slot);
		end
	end

	// Drive one input transfer: idle at random, then hold valid until accepted.
	task automatic send_item(logic [ACTION_W-1:0] act, logic [PIXEL_W-1:0] pix,
			logic [VALUE_W-1:0] val, logic [SLOT_W-1:0] slot);
		while (!calm && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		pixel_index <= pix;
		pixel_value <= val;
		sample_slot <= slot;
		if (act == ACT_INIT)
			primed[int'(pix)] = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid, drain every pending result, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.fg_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; only call while drained.
	task automatic write_regs(logic [CFG_DATA_W-1:0] radius_data,
			logic [CFG_DATA_W-1:0] min_data);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MATCH_RADIUS;
		cfg_wdata <= radius_data;
		@(posedge clk);
		cfg_index <= REG_MIN_MATCHES;
		cfg_wdata <= min_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(REG_MATCH_RADIUS, radius_data);
		board.set_reg(REG_MIN_MATCHES, min_data);
		cur_radius = int'(radius_data);
	endtask

	function automatic logic [VALUE_W-1:0] near_value(int base, int spread);
		int v;
		v = base + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[VALUE_W-1:0];
	endfunction

	// Random traffic around a pool of pixels, each with a drifting base grey level,
	// so that detects land near, at and beyond the match radius.
	task automatic run_random(int count);
		int k;
		int roll;
		int pix;
		logic [VALUE_W-1:0] val;
		for (int i = 0; i < count; i++) begin
			k    = $urandom_range(23);
			pix  = pool_pix[k];
			roll = $urandom_range(99);
			if (!primed.exists(pix) || roll < 12) begin
				if ($urandom_range(4) == 0)
					pool_base[k] = $urandom_range(255);
				send_item(ACT_INIT, PIXEL_W'(pix), near_value(pool_base[k], 6),
					SLOT_W'($urandom_range(31)));
			end else if (roll < 60) begin
				if ($urandom_range(9) < 7)
					val = near_value(pool_base[k], cur_radius + 10);
				else
					val = VALUE_W'($urandom_range(255));
				send_item(ACT_DETECT, PIXEL_W'(pix), val, SLOT_W'($urandom_range(31)));
			end else if (roll < 88) begin
				send_item(ACT_REPLACE, PIXEL_W'(pix), near_value(pool_base[k], 12),
					SLOT_W'(($urandom_range(9) == 0) ? $urandom_range(31, NUM_SAMPLES)
					                                 : $urandom_range(NUM_SAMPLES - 1)));
			end else if (roll < 93) begin
				// Unused action code: no change, flag stays low.
				send_item(2'd3, PIXEL_W'($urandom_range(MAX_PIXELS - 1)),
					VALUE_W'($urandom_range(255)), SLOT_W'($urandom_range(31)));
			end else begin
				// Write to a random pixel anywhere in the store.
				send_item($urandom_range(1) ? ACT_INIT : ACT_REPLACE,
					PIXEL_W'($urandom_range(MAX_PIXELS - 1)),
					VALUE_W'($urandom_range(255)), SLOT_W'($urandom_range(31)));
			end
		end
	endtask

	// Register settings per phase; extremes first, then a random one.
	int radius_plan [10] = '{20, 0, 255, 1, 35, 15, 50, 255, 8, 0};
	int min_plan    [10] = '{2, 2, 20, 1, 0, 21, 31, 1, 'hE5, 0};

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass at reset values: radius 20, two matches needed.
		send_item(ACT_INIT, 0, 8'd0, 5'd0);
		send_item(ACT_INIT, PIXEL_W'(MAX_PIXELS - 1), 8'd255, 5'd31);
		send_item(ACT_DETECT, 0, 8'd0, 5'd0);
		send_item(ACT_DETECT, 0, 8'd19, 5'd0);
		send_item(ACT_DETECT, 0, 8'd20, 5'd0);
		send_item(ACT_DETECT, PIXEL_W'(MAX_PIXELS - 1), 8'd255, 5'd31);
		send_item(ACT_DETECT, PIXEL_W'(MAX_PIXELS - 1), 8'd236, 5'd31);
		send_item(ACT_DETECT, PIXEL_W'(MAX_PIXELS - 1), 8'd235, 5'd31);
		// Exactly two matching samples, then one; slots past the last are ignored.
		send_item(ACT_REPLACE, 0, 8'd100, 5'd0);
		send_item(ACT_REPLACE, 0, 8'd100, 5'd19);
		send_item(ACT_REPLACE, 0, 8'd100, 5'd20);
		send_item(ACT_REPLACE, 0, 8'd100, 5'd31);
		send_item(ACT_DETECT, 0, 8'd100, 5'd0);
		send_item(ACT_REPLACE, 0, 8'd200, 5'd19);
		send_item(ACT_DETECT, 0, 8'd100, 5'd0);
		send_item(2'd3, 0, 8'd100, 5'd19);
		send_item(ACT_DETECT, 0, 8'd100, 5'd0);
		// Alternating bit patterns on index, value and slot.
		send_item(ACT_INIT, 17'h0AAAA, 8'hAA, 5'h15);
		send_item(ACT_DETECT, 17'h0AAAA, 8'hAA, 5'h0A);
		send_item(ACT_INIT, 17'h15555, 8'h55, 5'h0A);
		send_item(ACT_REPLACE, 17'h15555, 8'hAA, 5'h0A);
		send_item(ACT_REPLACE, 17'h15555, 8'hAA, 5'h15);
		send_item(ACT_DETECT, 17'h15555, 8'h55, 5'h15);

		pool_pix[0] = 0;
		pool_pix[1] = MAX_PIXELS - 1;
		for (int k = 2; k < 24; k++)
			pool_pix[k] = $urandom_range(MAX_PIXELS - 1);
		for (int k = 0; k < 24; k++)
			pool_base[k] = $urandom_range(255);
		pool_base[2] = 0;
		pool_base[3] = 255;

		radius_plan[9] = $urandom_range(255);
		min_plan[9]    = $urandom_range(255);
		for (int p = 0; p < 10; p++) begin
			drain();
			write_regs(CFG_DATA_W'(radius_plan[p]), CFG_DATA_W'(min_plan[p]));
			calm = (p == 3);
			run_random(68);
		end
		calm = 1'b0;

		drain();
		if (board.errors == 0)
			$display("vibe_pixel_model_classifier_unit_test: done, clean");
		else
			$display("vibe_pixel_model_classifier_unit_test: done, errors");
		$finish;
	end

	// Hard stop in case a transfer or a result never arrives.
	initial begin
		#2_000_000;
		$display("vibe_pixel_model_classifier_unit_test: done, errors");
		$finish;
	end

endmodule
